// ----- hdl/phr_pkg.sv -----
package phr_pkg;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_SR   = 2'd1,
        MODE_CHIP = 2'd2
    } mode_t;

    localparam logic [1:0] CFG_SR_CONFIRM   = 2'd0;
    localparam logic [1:0] CFG_CHIP_CONFIRM = 2'd1;
    localparam logic [1:0] CFG_CHIP_FAIL    = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PAD16 = 2'd1;
    localparam logic [1:0] KIND_STICK = 2'd2;
    localparam logic [1:0] KIND_CUBE  = 2'd3;

    localparam logic [2:0] MENU_NONE   = 3'd0;
    localparam logic [2:0] MENU_ALL    = 3'd1;
    localparam logic [2:0] MENU_LR     = 3'd2;
    localparam logic [2:0] MENU_UD     = 3'd3;
    localparam logic [2:0] MENU_UDR    = 3'd4;
    localparam logic [2:0] MENU_ULR    = 3'd5;
    localparam logic [2:0] MENU_UDL    = 3'd6;

    localparam logic [7:0] AXIS_CENTER = 8'h80;
    localparam logic [3:0] HAT_CENTER  = 4'd8;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 80;

    typedef struct packed {
        logic [7:0] sr_confirm_reads;
        logic [7:0] chip_confirm_reads;
        logic [7:0] chip_fail_limit;
    } cfg_t;

    typedef struct packed {
        mode_t      poll_mode;
        logic [3:0] held_dpad;
        logic [2:0] held_menu;
        logic [7:0] good_count;
        logic [7:0] fail_count;
    } state_t;

    typedef struct packed {
        logic [7:0]  axis_six;
        logic [7:0]  axis_five;
        logic [7:0]  axis_four;
        logic [7:0]  axis_three;
        logic [7:0]  axis_two;
        logic [7:0]  axis_one;
        logic [7:0]  chip_byte_two;
        logic [7:0]  chip_byte_one;
        logic        sr_trailing;
        logic [15:0] sr_word;
    } poll_t;

    typedef struct packed {
        logic        report_sent;
        logic [1:0]  report_mode;
        logic [1:0]  device_kind;
        logic [15:0] button_bits;
        logic [3:0]  hat_value;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [7:0]  stick_rx;
        logic [7:0]  stick_ry;
        logic [7:0]  trigger_left;
        logic [7:0]  trigger_right;
        logic [1:0]  next_mode;
    } report_t;

    // dpad bits: 3 up, 2 down, 1 left, 0 right (active high)
    function automatic logic [3:0] hat_of_dpad(input logic [3:0] dpad);
        logic [3:0] hat;
        case (dpad)
            4'h1:    hat = 4'd2;
            4'h2:    hat = 4'd6;
            4'h4:    hat = 4'd4;
            4'h5:    hat = 4'd3;
            4'h6:    hat = 4'd5;
            4'h8:    hat = 4'd0;
            4'h9:    hat = 4'd1;
            4'hA:    hat = 4'd7;
            default: hat = HAT_CENTER;
        endcase
        return hat;
    endfunction

    function automatic logic [2:0] menu_code(input logic [3:0] dpad);
        logic [2:0] code;
        case (dpad)
            4'hF:    code = MENU_ALL;
            4'hC:    code = MENU_LR;
            4'h3:    code = MENU_UD;
            4'hD:    code = MENU_UDR;
            4'hB:    code = MENU_ULR;
            4'hE:    code = MENU_UDL;
            default: code = MENU_NONE;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/phr_decode.sv -----
module phr_decode (
    input  phr_pkg::cfg_t    cfg,
    input  phr_pkg::state_t  state,
    input  phr_pkg::poll_t   poll,
    output phr_pkg::state_t  state_next,
    output phr_pkg::report_t report
);
    import phr_pkg::*;

    report_t    neutral;
    report_t    blank;
    logic [15:0] nv;
    logic [3:0] sr_dpad;
    logic       sr_plus;
    logic       sr_minus;
    logic [3:0] sr_held;
    logic [15:0] sr_btn;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       present;
    logic       cube;
    logic [3:0] chip_dpad;
    logic [2:0] code;
    logic [2:0] menu_new;
    logic [3:0] chip_held;
    logic [15:0] chip_btn;

    always_comb
    begin
        neutral = '0;
        neutral.report_sent = 1'b1;
        neutral.hat_value   = HAT_CENTER;
        neutral.stick_x     = AXIS_CENTER;
        neutral.stick_y     = AXIS_CENTER;
        neutral.stick_rx    = AXIS_CENTER;
        neutral.stick_ry    = AXIS_CENTER;
        blank = '0;
    end

    // shift-register pad decode
    always_comb
    begin
        nv = ~poll.sr_word;
        sr_dpad = {nv[9:8], nv[5:4]};
        sr_plus  = (sr_dpad[1:0] == 2'b11);
        sr_minus = (sr_dpad[3:2] == 2'b11);
        // opposite directions held together keep the previous direction
        sr_held = {sr_minus ? state.held_dpad[3:2] : sr_dpad[3:2],
                   sr_plus  ? state.held_dpad[1:0] : sr_dpad[1:0]};
        sr_btn = '0;
        sr_btn[0]  = nv[13];
        sr_btn[1]  = nv[3];
        sr_btn[2]  = nv[12];
        sr_btn[3]  = nv[2];
        sr_btn[4]  = nv[11];
        sr_btn[5]  = nv[10];
        sr_btn[6]  = nv[1];
        sr_btn[7]  = nv[0];
        sr_btn[10] = nv[14];
        sr_btn[12] = sr_plus;
        sr_btn[13] = nv[15];
        sr_btn[15] = sr_minus;
    end

    // chip pad decode
    always_comb
    begin
        b1 = poll.chip_byte_one;
        b2 = poll.chip_byte_two;
        present = b2[7];
        cube    = b2[6];
        chip_dpad = ~b1[3:0];
        code      = MENU_NONE;
        menu_new  = state.held_menu;
        chip_held = state.held_dpad;
        if ((chip_dpad[1:0] == 2'b11) || (chip_dpad[3:2] == 2'b11))
        begin
            // opposite directions are menu keys, only while no direction is held
            if (state.held_dpad == 4'h0)
            begin
                code = menu_code(chip_dpad);
                if (state.held_menu == MENU_NONE)
                    menu_new = code;
                if (menu_new != code)
                    code = menu_new;
            end
        end
        else
        begin
            chip_held = chip_dpad;
            menu_new  = MENU_NONE;
        end
        chip_btn = '0;
        chip_btn[0]  = ~b1[6];
        chip_btn[1]  = ~b1[7];
        chip_btn[2]  = ~b2[3];
        chip_btn[3]  = ~b2[2];
        chip_btn[4]  = ~b1[5];
        chip_btn[5]  = ~b1[4];
        chip_btn[6]  = ~b2[5];
        chip_btn[7]  = ~b2[4];
        chip_btn[8]  = ~cube & ~b2[1];
        chip_btn[9]  = ~cube & ~b2[0];
        chip_btn[10] = (code == MENU_ULR);
        chip_btn[11] = (code == MENU_ALL);
        chip_btn[12] = (code == MENU_LR);
        chip_btn[13] = (code == MENU_UDL);
        chip_btn[14] = (code == MENU_UDR);
        chip_btn[15] = (code == MENU_UD);
    end

    always_comb
    begin
        state_next = state;
        report     = blank;
        unique case (state.poll_mode)
            MODE_SR:
            begin
                if (poll.sr_trailing)
                begin
                    state_next = '0;
                    state_next.poll_mode = MODE_CHIP;
                    report.next_mode = MODE_CHIP;
                end
                else if (state.good_count < cfg.sr_confirm_reads)
                begin
                    state_next.good_count = state.good_count + 8'd1;
                    report = neutral;
                    report.report_mode = MODE_SR;
                    report.next_mode   = MODE_SR;
                end
                else
                begin
                    state_next.held_dpad = sr_held;
                    report = neutral;
                    report.report_mode = MODE_SR;
                    report.next_mode   = MODE_SR;
                    report.device_kind = KIND_PAD16;
                    report.button_bits = sr_btn;
                    report.hat_value   = hat_of_dpad(sr_held);
                end
            end
            MODE_CHIP:
            begin
                if (!present || (cube && b2[0]))
                begin
                    if (state.fail_count < cfg.chip_fail_limit)
                    begin
                        state_next.fail_count = state.fail_count + 8'd1;
                        report.next_mode = MODE_CHIP;
                    end
                    else
                    begin
                        state_next = '0;
                        state_next.poll_mode = MODE_NONE;
                        report.next_mode = MODE_NONE;
                    end
                end
                else
                begin
                    state_next.fail_count = '0;
                    state_next.held_dpad  = chip_held;
                    state_next.held_menu  = menu_new;
                    report = neutral;
                    report.report_mode = MODE_CHIP;
                    report.next_mode   = MODE_CHIP;
                    if (state.good_count < cfg.chip_confirm_reads)
                    begin
                        state_next.good_count = state.good_count + 8'd1;
                    end
                    else
                    begin
                        report.button_bits = chip_btn;
                        report.hat_value   = hat_of_dpad(chip_held);
                        if (cube)
                        begin
                            report.device_kind   = KIND_CUBE;
                            report.stick_x       = poll.axis_one;
                            report.stick_y       = ~poll.axis_two;
                            report.stick_rx      = poll.axis_three;
                            report.stick_ry      = ~poll.axis_four;
                            report.trigger_left  = poll.axis_five;
                            report.trigger_right = poll.axis_six;
                        end
                        else
                        begin
                            // x + 128 and 127 - y, both modulo 256
                            report.device_kind = KIND_STICK;
                            report.stick_x = {~poll.axis_one[7], poll.axis_one[6:0]};
                            report.stick_y = {poll.axis_two[7], ~poll.axis_two[6:0]};
                        end
                    end
                end
            end
            default:
            begin
                // none mode and the unused code
                state_next = '0;
                state_next.poll_mode = MODE_SR;
                report = neutral;
                report.report_mode = MODE_NONE;
                report.next_mode   = MODE_SR;
            end
        endcase
    end

endmodule

// ----- hdl/pad_poll_to_hid_report_core.sv -----
// Pad poll to gamepad report core.
// Slave stream (s_*) takes one finished poll frame per transfer; master stream
// (m_*) gives exactly one report per frame, in order. A report with
// report_sent low carries only next_mode, which tells the port logic which
// protocol to poll next.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 sr_confirm_reads, 1 chip_confirm_reads, 2 chip_fail_limit); other
// indexes are ignored. Write only while no frame is in flight.
// Path: a frame is captured in the input register, then decoded into the report
// register, which drives m_tvalid. Throughput: one frame per cycle while the
// receiver does not stall; the decode and its small state feedback fit between
// the two registers.
// When the receiver stalls, the report register holds and the input register
// keeps one more frame; s_tready drops only when both are full.
// Reset (rst_n low, asynchronous) empties both registers, sets none mode,
// clears the held d-pad, menu code and counters, and loads the register
// defaults 15, 15 and 5.
module pad_poll_to_hid_report_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sr_word, sr_trailing, chip_byte_one, chip_byte_two, axis_one .. axis_six
    input  logic [phr_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // report_sent, report_mode, button_bits, hat_value, stick_x, stick_y,
    // stick_rx, stick_ry, trigger_left, trigger_right, next_mode
    output logic [phr_pkg::OUT_DATA_W-1:0] m_tdata,
    // device_kind
    output logic [1:0]  m_tuser
);
    import phr_pkg::*;

    localparam int POLL_W = $bits(poll_t);
    localparam int REP_W  = $bits(report_t) - 2;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    logic    in_valid_reg;
    poll_t   in_data_reg;
    logic    out_valid_reg;
    report_t out_data_reg;
    report_t report_next;
    logic    advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sr_confirm_reads   <= 8'd15;
            cfg_reg.chip_confirm_reads <= 8'd15;
            cfg_reg.chip_fail_limit    <= 8'd5;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SR_CONFIRM:   cfg_reg.sr_confirm_reads   <= cfg_data;
                CFG_CHIP_CONFIRM: cfg_reg.chip_confirm_reads <= cfg_data;
                CFG_CHIP_FAIL:    cfg_reg.chip_fail_limit    <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= poll_t'(s_tdata[POLL_W-1:0]);
        if (advance)
            out_data_reg <= report_next;
    end

    phr_decode u_decode (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .poll       (in_data_reg),
        .state_next (state_next),
        .report     (report_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.device_kind;
    assign m_tdata  = {{(OUT_DATA_W-REP_W){1'b0}},
                       out_data_reg.next_mode,
                       out_data_reg.trigger_right,
                       out_data_reg.trigger_left,
                       out_data_reg.stick_ry,
                       out_data_reg.stick_rx,
                       out_data_reg.stick_y,
                       out_data_reg.stick_x,
                       out_data_reg.hat_value,
                       out_data_reg.button_bits,
                       out_data_reg.report_mode,
                       out_data_reg.report_sent};

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while a stage is free");

    a_advance_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded frame did not reach the report register");

    a_none_mode_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.poll_mode == MODE_NONE) |=>
        (state_reg.poll_mode == MODE_SR && state_reg.good_count == 8'd0 &&
         state_reg.fail_count == 8'd0 && state_reg.held_dpad == 4'h0))
        else $error("none mode did not clear the state");

    a_blank_report: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.report_sent) |->
        (out_data_reg.button_bits == 16'h0000 && out_data_reg.device_kind == KIND_NONE &&
         out_data_reg.hat_value == 4'd0 && out_data_reg.stick_x == 8'h00))
        else $error("report without report_sent carries data");

    a_mode_follows_next: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg.poll_mode == mode_t'(out_data_reg.next_mode)))
        else $error("next_mode disagrees with the stored mode");

endmodule

// ----- verif/pad_poll_to_hid_report_core_test.sv -----
`timescale 1ns / 1ps

module pad_poll_to_hid_report_core_test;

    import phr_pkg::*;

    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;

    pad_poll_to_hid_report_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // predicted block state and register copy
    cfg_t mdl_cfg = '{8'd15, 8'd15, 8'd5};
    mode_t mdl_mode = MODE_NONE;
    logic [3:0] mdl_dpad = '0;
    logic [2:0] mdl_menu = '0;
    logic [7:0] mdl_good = '0;
    logic [7:0] mdl_fail = '0;

    poll_t poll_queue[$];
    report_t pending_reports[$];

    int mismatch_count = 0;
    int delivered = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int pattern_age = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    bit offer_next;
    report_t seen;
    report_t want;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [3:0] hat_for(input logic [3:0] dpad);
        logic [3:0] hat;
        case (dpad)
            4'h1:    hat = 4'd2;
            4'h2:    hat = 4'd6;
            4'h4:    hat = 4'd4;
            4'h5:    hat = 4'd3;
            4'h6:    hat = 4'd5;
            4'h8:    hat = 4'd0;
            4'h9:    hat = 4'd1;
            4'hA:    hat = 4'd7;
            default: hat = HAT_CENTER;
        endcase
        return hat;
    endfunction

    function automatic report_t neutral_report(input logic [1:0] mode, input logic [1:0] next);
        report_t r;
        r = '0;
        r.report_sent = 1'b1;
        r.report_mode = mode;
        r.hat_value = HAT_CENTER;
        r.stick_x = AXIS_CENTER;
        r.stick_y = AXIS_CENTER;
        r.stick_rx = AXIS_CENTER;
        r.stick_ry = AXIS_CENTER;
        r.next_mode = next;
        return r;
    endfunction

    function automatic void clear_held();
        mdl_dpad = '0;
        mdl_menu = MENU_NONE;
        mdl_good = '0;
        mdl_fail = '0;
    endfunction

    // one poll frame in, one report out; updates the predicted state
    function automatic report_t decode_poll(input poll_t p);
        report_t r;
        logic [15:0] nv;
        logic [15:0] btn;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [3:0] dpad;
        logic [2:0] code;
        logic plus_key;
        logic minus_key;
        r = '0;
        btn = '0;
        b1 = p.chip_byte_one;
        b2 = p.chip_byte_two;
        case (mdl_mode)
            MODE_SR:
            begin
                if (p.sr_trailing)
                begin
                    mdl_mode = MODE_CHIP;
                    clear_held();
                    r.next_mode = MODE_CHIP;
                end
                else if (mdl_good < mdl_cfg.sr_confirm_reads)
                begin
                    mdl_good++;
                    r = neutral_report(MODE_SR, MODE_SR);
                end
                else
                begin
                    nv = ~p.sr_word;
                    dpad = {nv[9], nv[8], nv[5], nv[4]};
                    plus_key = (dpad[1:0] == 2'b11);
                    minus_key = (dpad[3:2] == 2'b11);
                    // opposite directions fall back to the last held ones
                    if (plus_key)
                        dpad[1:0] = mdl_dpad[1:0];
                    if (minus_key)
                        dpad[3:2] = mdl_dpad[3:2];
                    mdl_dpad = dpad;
                    btn[0] = nv[13];
                    btn[1] = nv[3];
                    btn[2] = nv[12];
                    btn[3] = nv[2];
                    btn[4] = nv[11];
                    btn[5] = nv[10];
                    btn[6] = nv[1];
                    btn[7] = nv[0];
                    btn[10] = nv[14];
                    btn[12] = plus_key;
                    btn[13] = nv[15];
                    btn[15] = minus_key;
                    r = neutral_report(MODE_SR, MODE_SR);
                    r.device_kind = KIND_PAD16;
                    r.button_bits = btn;
                    r.hat_value = hat_for(mdl_dpad);
                end
            end
            MODE_CHIP:
            begin
                if (!b2[7] || (b2[6] && b2[0]))
                begin
                    if (mdl_fail < mdl_cfg.chip_fail_limit)
                    begin
                        mdl_fail++;
                        r.next_mode = MODE_CHIP;
                    end
                    else
                    begin
                        mdl_mode = MODE_NONE;
                        clear_held();
                        r.next_mode = MODE_NONE;
                    end
                end
                else
                begin
                    mdl_fail = '0;
                    dpad = ~b1[3:0];
                    code = MENU_NONE;
                    if (dpad[1:0] == 2'b11 || dpad[3:2] == 2'b11)
                    begin
                        // menu keys only decode from a released d-pad
                        if (mdl_dpad == 4'h0)
                        begin
                            case (dpad)
                                4'hF:    code = MENU_ALL;
                                4'hC:    code = MENU_LR;
                                4'h3:    code = MENU_UD;
                                4'hD:    code = MENU_UDR;
                                4'hB:    code = MENU_ULR;
                                4'hE:    code = MENU_UDL;
                                default: code = MENU_NONE;
                            endcase
                            if (mdl_menu == MENU_NONE)
                                mdl_menu = code;
                            if (mdl_menu != code)
                                code = mdl_menu;
                        end
                    end
                    else
                    begin
                        mdl_dpad = dpad;
                        mdl_menu = MENU_NONE;
                    end
                    if (mdl_good < mdl_cfg.chip_confirm_reads)
                    begin
                        mdl_good++;
                        r = neutral_report(MODE_CHIP, MODE_CHIP);
                    end
                    else
                    begin
                        btn[0] = !b1[6];
                        btn[1] = !b1[7];
                        btn[2] = !b2[3];
                        btn[3] = !b2[2];
                        btn[4] = !b1[5];
                        btn[5] = !b1[4];
                        btn[6] = !b2[5];
                        btn[7] = !b2[4];
                        btn[10] = (code == MENU_ULR);
                        btn[11] = (code == MENU_ALL);
                        btn[12] = (code == MENU_LR);
                        btn[13] = (code == MENU_UDL);
                        btn[14] = (code == MENU_UDR);
                        btn[15] = (code == MENU_UD);
                        r = neutral_report(MODE_CHIP, MODE_CHIP);
                        r.hat_value = hat_for(mdl_dpad);
                        if (b2[6])
                        begin
                            r.device_kind = KIND_CUBE;
                            r.stick_x = p.axis_one;
                            r.stick_y = ~p.axis_two;
                            r.stick_rx = p.axis_three;
                            r.stick_ry = ~p.axis_four;
                            r.trigger_left = p.axis_five;
                            r.trigger_right = p.axis_six;
                        end
                        else
                        begin
                            btn[8] = !b2[1];
                            btn[9] = !b2[0];
                            r.device_kind = KIND_STICK;
                            r.stick_x = p.axis_one + 8'd128;
                            r.stick_y = 8'd127 - p.axis_two;
                        end
                        r.button_bits = btn;
                    end
                end
            end
            default:
            begin
                clear_held();
                r = neutral_report(MODE_NONE, MODE_SR);
                mdl_mode = MODE_SR;
            end
        endcase
        return r;
    endfunction

    function automatic poll_t sr_frame(input logic [15:0] word, input logic trailing);
        poll_t p;
        p = '0;
        p.sr_word = word;
        p.sr_trailing = trailing;
        return p;
    endfunction

    function automatic poll_t chip_frame(input logic [7:0] b1, input logic [7:0] b2,
                                         input logic [7:0] axes);
        poll_t p;
        p = '0;
        p.chip_byte_one = b1;
        p.chip_byte_two = b2;
        p.axis_one = axes;
        p.axis_two = ~axes;
        p.axis_three = axes;
        p.axis_four = ~axes;
        p.axis_five = axes;
        p.axis_six = ~axes;
        return p;
    endfunction

    task automatic write_cfg(input logic [1:0] index, input logic [7:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_SR_CONFIRM:   mdl_cfg.sr_confirm_reads = value;
            CFG_CHIP_CONFIRM: mdl_cfg.chip_confirm_reads = value;
            CFG_CHIP_FAIL:    mdl_cfg.chip_fail_limit = value;
            default:          ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] sr_reads, input logic [7:0] chip_reads,
                              input logic [7:0] fail_limit);
        write_cfg(CFG_SR_CONFIRM, sr_reads);
        write_cfg(CFG_CHIP_CONFIRM, chip_reads);
        write_cfg(CFG_CHIP_FAIL, fail_limit);
        // index beyond the register file must be ignored
        write_cfg(CFG_UNUSED, 8'($urandom));
    endtask

    task automatic wait_idle();
        while (poll_queue.size() != 0 || pending_reports.size() != 0)
            @(posedge clk);
    endtask

    // assumes a fail limit of zero
    task automatic queue_directed();
        if (mdl_mode == MODE_SR)
            poll_queue.push_back(sr_frame(16'hFFFF, 1'b1));
        if (mdl_mode != MODE_NONE)
            poll_queue.push_back(chip_frame(8'hFF, 8'h00, 8'h00));
        poll_queue.push_back(sr_frame(16'h0000, 1'b0));
        poll_queue.push_back(sr_frame(16'hFFFF, 1'b0));
        poll_queue.push_back(sr_frame(16'h0000, 1'b0));
        poll_queue.push_back(sr_frame(~16'h0210, 1'b0));
        poll_queue.push_back(sr_frame(~16'h0230, 1'b0));
        poll_queue.push_back(sr_frame(~16'h0300, 1'b0));
        poll_queue.push_back(sr_frame(16'hAAAA, 1'b0));
        poll_queue.push_back(sr_frame(16'h5555, 1'b1));
        poll_queue.push_back(chip_frame(8'hFF, 8'h80, 8'h00));
        poll_queue.push_back(chip_frame(8'h00, 8'h80, 8'hFF));
        poll_queue.push_back(chip_frame(8'hF3, 8'hC0, 8'hFF));
        poll_queue.push_back(chip_frame(8'hFF, 8'hC0, 8'h00));
        poll_queue.push_back(chip_frame(8'hF3, 8'hC0, 8'h5A));
        poll_queue.push_back(chip_frame(8'hFC, 8'h80, 8'hA5));
        poll_queue.push_back(chip_frame(8'hFF, 8'h80, 8'h7F));
        poll_queue.push_back(chip_frame(8'hF2, 8'hC0, 8'h01));
        poll_queue.push_back(chip_frame(8'hF7, 8'h80, 8'hFE));
        poll_queue.push_back(chip_frame(8'hF0, 8'hC0, 8'h33));
        // cube pad with its fail bit set
        poll_queue.push_back(chip_frame(8'hFF, 8'hFF, 8'h00));
    endtask

    // mostly well-formed walks none -> shift register -> chip -> none
    task automatic queue_random(input int count);
        poll_t p;
        logic [95:0] raw;
        mode_t plan_mode;
        int plan_good;
        int plan_fail;
        int linger;
        bit leave;
        plan_mode = mdl_mode;
        plan_good = mdl_good;
        plan_fail = mdl_fail;
        linger = $urandom_range(0, 12);
        repeat (count)
        begin
            raw = {$urandom, $urandom, $urandom};
            p = raw[$bits(poll_t)-1:0];
            if ($urandom_range(0, 3) == 0)
                p.sr_word = ~(16'($urandom) & 16'($urandom) & 16'($urandom));
            if ($urandom_range(0, 2) == 0)
                p.chip_byte_one[3:0] = 4'hF;
            case (plan_mode)
                MODE_SR:
                begin
                    p.sr_trailing = (plan_good >= int'(mdl_cfg.sr_confirm_reads) + linger)
                                    || ($urandom_range(0, 40) == 0);
                    if (p.sr_trailing)
                    begin
                        plan_mode = MODE_CHIP;
                        plan_good = 0;
                        plan_fail = 0;
                        linger = $urandom_range(0, 12);
                    end
                    else
                        plan_good++;
                end
                MODE_CHIP:
                begin
                    leave = (plan_good >= int'(mdl_cfg.chip_confirm_reads) + linger)
                            || ($urandom_range(0, 7) == 0);
                    if (leave)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            p.chip_byte_two[7] = 1'b0;
                        else
                        begin
                            p.chip_byte_two[7:6] = 2'b11;
                            p.chip_byte_two[0] = 1'b1;
                        end
                        if (plan_fail < int'(mdl_cfg.chip_fail_limit))
                            plan_fail++;
                        else
                            plan_mode = MODE_NONE;
                    end
                    else
                    begin
                        p.chip_byte_two[7] = 1'b1;
                        if (p.chip_byte_two[6])
                            p.chip_byte_two[0] = 1'b0;
                        plan_fail = 0;
                        plan_good++;
                    end
                end
                default:
                begin
                    plan_mode = MODE_SR;
                    plan_good = 0;
                    plan_fail = 0;
                    linger = $urandom_range(0, 12);
                end
            endcase
            poll_queue.push_back(p);
        end
    endtask

    task automatic note_mismatch(input string what, input logic [79:0] exp_val,
                                 input logic [79:0] act_val);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("report %0d: %s mismatch, expected %0h, got %0h",
                     delivered, what, exp_val, act_val);
    endtask

    // sender: bursts of frames separated by random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pending_reports.push_back(decode_poll(poll_queue.pop_front()));
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                offer_next = 1'b0;
            end
            else
                offer_next = s_tvalid;
            if (!offer_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (poll_queue.size() != 0)
                    offer_next = 1'b1;
            end
            s_tvalid <= offer_next;
            if (offer_next)
                s_tdata <= IN_DATA_W'(poll_queue[0]);
        end
    end

    // receiver: checks each report transfer and stalls on a rotating pattern
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                seen.report_sent = m_tdata[0];
                seen.report_mode = m_tdata[2:1];
                seen.device_kind = m_tuser;
                seen.button_bits = m_tdata[18:3];
                seen.hat_value = m_tdata[22:19];
                seen.stick_x = m_tdata[30:23];
                seen.stick_y = m_tdata[38:31];
                seen.stick_rx = m_tdata[46:39];
                seen.stick_ry = m_tdata[54:47];
                seen.trigger_left = m_tdata[62:55];
                seen.trigger_right = m_tdata[70:63];
                seen.next_mode = m_tdata[72:71];
                if (pending_reports.size() == 0)
                    note_mismatch("unexpected report", '0, m_tdata);
                else
                begin
                    want = pending_reports.pop_front();
                    if (seen.report_sent !== want.report_sent)
                        note_mismatch("report_sent", want.report_sent, seen.report_sent);
                    if (seen.report_mode !== want.report_mode)
                        note_mismatch("report_mode", want.report_mode, seen.report_mode);
                    if (seen.device_kind !== want.device_kind)
                        note_mismatch("device_kind", want.device_kind, seen.device_kind);
                    if (seen.button_bits !== want.button_bits)
                        note_mismatch("button_bits", want.button_bits, seen.button_bits);
                    if (seen.hat_value !== want.hat_value)
                        note_mismatch("hat_value", want.hat_value, seen.hat_value);
                    if (seen.stick_x !== want.stick_x)
                        note_mismatch("stick_x", want.stick_x, seen.stick_x);
                    if (seen.stick_y !== want.stick_y)
                        note_mismatch("stick_y", want.stick_y, seen.stick_y);
                    if (seen.stick_rx !== want.stick_rx)
                        note_mismatch("stick_rx", want.stick_rx, seen.stick_rx);
                    if (seen.stick_ry !== want.stick_ry)
                        note_mismatch("stick_ry", want.stick_ry, seen.stick_ry);
                    if (seen.trigger_left !== want.trigger_left)
                        note_mismatch("trigger_left", want.trigger_left, seen.trigger_left);
                    if (seen.trigger_right !== want.trigger_right)
                        note_mismatch("trigger_right", want.trigger_right, seen.trigger_right);
                    if (seen.next_mode !== want.next_mode)
                        note_mismatch("next_mode", want.next_mode, seen.next_mode);
                end
                delivered++;
                // long back-pressure so the input side fills and stalls
                if (delivered == 150 || delivered == 420)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
                hold_left--;
            if (pattern_age == 0)
            begin
                ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                              : (16'($urandom) | 16'h0001);
                pattern_age = $urandom_range(16, 64);
            end
            else
                pattern_age--;
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            m_tready <= (hold_left == 0) && ready_pattern[0];
        end
    end

    // counts cycles without any transfer while work is outstanding
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (poll_queue.size() == 0 && pending_reports.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[pad_poll_to_hid_report_core] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults first
        queue_random(60);
        wait_idle();

        set_config(8'd0, 8'd0, 8'd0);
        queue_directed();
        wait_idle();
        queue_random(100);
        wait_idle();

        set_config(8'd3, 8'd2, 8'd1);
        queue_random(120);
        wait_idle();

        set_config(8'd255, 8'd255, 8'd255);
        queue_random(80);
        wait_idle();

        set_config(8'd1, 8'd0, 8'd3);
        queue_random(120);
        wait_idle();

        set_config(8'd6, 8'd4, 8'd2);
        queue_random(120);
        wait_idle();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_reports.size() == 0)
            $display("[pad_poll_to_hid_report_core] OK");
        else
            $display("[pad_poll_to_hid_report_core] ERROR");
        $finish;
    end

endmodule
